// ----- hdl/lrf_pkg.sv -----
// Shared types and constants of the line receive FIFO.
package lrf_pkg;

  // Default number of byte slots; one slot always stays free
  localparam int unsigned Depth = 32;

  // Most results one line read may give: kept bytes plus the final beat
  localparam int unsigned MaxResults = 32;
  localparam int unsigned KeptW      = $clog2(MaxResults);

  // Reset value of the line capacity register
  localparam logic [7:0] CapReset = 8'd64;

  // Characters the line reader looks for
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChCr = 8'h0D;

  // Operation codes of the kind field
  localparam logic [1:0] KindPush = 2'd0;
  localparam logic [1:0] KindPop  = 2'd1;
  localparam logic [1:0] KindLine = 2'd2;

  // Status codes of a result
  localparam logic [1:0] StatOk    = 2'd0;
  localparam logic [1:0] StatFull  = 2'd1;
  localparam logic [1:0] StatEmpty = 2'd2;

  // Input beat
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_in;
  } lrf_in_t;

  // Result beat
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data_byte;
    logic [7:0] line_length;
    logic       line_ready;
    logic       last;
  } lrf_out_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_EXAM  = 4'b0100,
    ST_FINAL = 4'b1000
  } lrf_state_e;

endpackage

// ----- hdl/line_receive_fifo.sv -----
// Byte receive FIFO with a registered-read store and a line-reading sequencer.
//
// Usage:
//   An operation is taken at a clock edge where start_i is high and busy_o is
//   low; req_i.kind picks push, pop or line read, req_i.byte_in is the pushed
//   byte. Each result beat sits on rsp_o for exactly one cycle, flagged by
//   done_o; the receiver cannot stall, so it must take every beat. The last
//   beat of an operation has rsp_o.last set.
//   Push, an empty pop, a line read of an empty FIFO and the unused code each
//   give their result the cycle after acceptance, and busy_o never rises, so
//   a new operation may follow in the next cycle.
//   A pop of a stored byte runs in steps: the accepting cycle addresses the
//   store, ST_FETCH registers its read data, ST_EXAM examines and answers.
//   A line read of a non-empty FIFO pops each byte through ST_FETCH and
//   ST_EXAM (the store read is registered), and ends in ST_FINAL for the
//   final beat when the FIFO runs dry before a newline. busy_o is high from
//   the cycle after acceptance to the end of the read.
//   cfg_we_i writes the line capacity from cfg_wdata_i; write it only while
//   the block is idle.
//   Reset empties the FIFO, clears the newline count and sets the capacity to
//   64. The store itself is not cleared; only written slots are ever read.
module line_receive_fifo #(
  parameter int unsigned DEPTH = lrf_pkg::Depth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  lrf_pkg::lrf_in_t req_i,
  output logic             busy_o,
  output logic             done_o,
  output lrf_pkg::lrf_out_t rsp_o,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_wdata_i
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned KW   = lrf_pkg::KeptW;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [KW-1:0]   KeptMax = KW'(lrf_pkg::MaxResults - 1);

  // Byte store, written at the write pointer and read at the read pointer
  logic [7:0] store_q [DEPTH];
  logic [7:0] rd_q;

  lrf_pkg::lrf_state_e state_q, state_d;
  logic [PtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [PtrW-1:0] cnt_q, cnt_d;
  logic [7:0]      cap_q;
  logic [KW-1:0]   lim_q, lim_d, kept_q, kept_d;
  logic            is_line_q, is_line_d;
  logic            done_q, done_d;
  lrf_pkg::lrf_out_t rsp_q, rsp_d;

  logic            accept;
  logic            wr_en;
  logic [PtrW-1:0] wp_nx, rp_nx;
  logic            full, empty;
  logic            push_lf;
  logic [PtrW-1:0] cnt_pop;
  logic [7:0]      cap_m1;

  assign accept  = start_i && (state_q == lrf_pkg::ST_IDLE);
  assign wp_nx   = (wp_q == PtrLast) ? '0 : wp_q + 1'b1;
  assign rp_nx   = (rp_q == PtrLast) ? '0 : rp_q + 1'b1;
  assign full    = (wp_nx == rp_q);
  assign empty   = (wp_q == rp_q);
  assign push_lf = (req_i.byte_in == lrf_pkg::ChLf);
  assign cap_m1  = cap_q - 8'd1;
  // Count after popping the registered byte
  assign cnt_pop = ((rd_q == lrf_pkg::ChLf) && (cnt_q != '0)) ? cnt_q - 1'b1 : cnt_q;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    rp_d      = rp_q;
    cnt_d     = cnt_q;
    lim_d     = lim_q;
    kept_d    = kept_q;
    is_line_d = is_line_q;
    wr_en     = 1'b0;
    done_d    = 1'b0;
    rsp_d     = '0;
    rsp_d.status = lrf_pkg::StatOk;

    unique case (state_q)
      lrf_pkg::ST_IDLE: begin
        if (accept) begin
          rsp_d.last       = 1'b1;
          rsp_d.line_ready = (cnt_q != '0);
          // Clamp the kept limit to capacity minus one and to the result bound
          if (cap_q == 8'd0) begin
            lim_d = '0;
          end else if (cap_m1 > 8'(KeptMax)) begin
            lim_d = KeptMax;
          end else begin
            lim_d = cap_m1[KW-1:0];
          end
          kept_d = '0;
          case (req_i.kind)
            lrf_pkg::KindPush: begin
              done_d = 1'b1;
              if (full) begin
                rsp_d.status = lrf_pkg::StatFull;
              end else begin
                wr_en = 1'b1;
                wp_d  = wp_nx;
                if (push_lf) begin
                  cnt_d = cnt_q + 1'b1;
                end
                rsp_d.line_ready = push_lf || (cnt_q != '0);
              end
            end
            lrf_pkg::KindPop,
            lrf_pkg::KindLine: begin
              is_line_d = (req_i.kind == lrf_pkg::KindLine);
              if (empty) begin
                done_d = 1'b1;
                if (req_i.kind == lrf_pkg::KindPop) begin
                  rsp_d.status = lrf_pkg::StatEmpty;
                end
              end else begin
                state_d = lrf_pkg::ST_FETCH;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      lrf_pkg::ST_FETCH: begin
        state_d = lrf_pkg::ST_EXAM;
      end

      lrf_pkg::ST_EXAM: begin
        // Pop the registered byte
        rp_d  = rp_nx;
        cnt_d = cnt_pop;
        if (!is_line_q) begin
          done_d           = 1'b1;
          rsp_d.data_byte  = rd_q;
          rsp_d.line_ready = (cnt_pop != '0);
          rsp_d.last       = 1'b1;
          state_d          = lrf_pkg::ST_IDLE;
        end else if (rd_q == lrf_pkg::ChLf) begin
          done_d            = 1'b1;
          rsp_d.line_length = 8'(kept_q);
          rsp_d.line_ready  = (cnt_pop != '0);
          rsp_d.last        = 1'b1;
          state_d           = lrf_pkg::ST_IDLE;
        end else begin
          // No newline yet: a stored newline survives this read only if two were held
          if ((rd_q != lrf_pkg::ChCr) && (kept_q < lim_q)) begin
            done_d           = 1'b1;
            rsp_d.data_byte  = rd_q;
            rsp_d.line_ready = (cnt_q > PtrW'(1));
            kept_d           = kept_q + 1'b1;
          end
          state_d = (rp_nx == wp_q) ? lrf_pkg::ST_FINAL : lrf_pkg::ST_FETCH;
        end
      end

      lrf_pkg::ST_FINAL: begin
        done_d            = 1'b1;
        rsp_d.line_length = 8'(kept_q);
        rsp_d.line_ready  = (cnt_q != '0);
        rsp_d.last        = 1'b1;
        state_d           = lrf_pkg::ST_IDLE;
      end

      default: begin
        state_d = lrf_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lrf_pkg::ST_IDLE;
      wp_q      <= '0;
      rp_q      <= '0;
      cnt_q     <= '0;
      cap_q     <= lrf_pkg::CapReset;
      lim_q     <= '0;
      kept_q    <= '0;
      is_line_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      cnt_q     <= cnt_d;
      lim_q     <= lim_d;
      kept_q    <= kept_d;
      is_line_q <= is_line_d;
      done_q    <= done_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // Result beat register
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  // Store write and registered read at the read pointer
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wp_q] <= req_i.byte_in;
    end
    rd_q <= store_q[rp_q];
  end

  assign busy_o = (state_q != lrf_pkg::ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTH
  logic [PtrW:0] occ;
  assign occ = (wp_q >= rp_q) ? {1'b0, wp_q} - {1'b0, rp_q}
                              : {1'b0, wp_q} + (PtrW+1)'(DEPTH) - {1'b0, rp_q};

  a_cnt_le_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, cnt_q} <= occ)
    else $error("newline count exceeds FIFO occupancy");

  a_kept_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= lim_q || state_q == lrf_pkg::ST_IDLE)
    else $error("line read kept more bytes than its limit");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.last |-> !busy_o)
    else $error("final beat shown while sequencer still busy");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.kind == lrf_pkg::KindPop && empty
    |=> done_o && rsp_o.status == lrf_pkg::StatEmpty && rsp_o.last)
    else $error("empty pop did not report empty");

  a_len_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.line_length != 8'd0 |-> rsp_o.last && rsp_o.data_byte == 8'd0)
    else $error("line length on a non-final beat");
`endif

endmodule
